[src/mwfb_pkg.sv]
// Shared constants, types and the CRC function of the Modbus write frame builder.
package mwfb_pkg;

    localparam int unsigned MAX_REGISTERS = 123;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_WRITE_MULTI = 8'h10;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        first;
        logic        multi;
        logic        last;
        logic [7:0]  station_addr;
        logic [15:0] start_register;
        logic [6:0]  register_count;
        logic [15:0] register_value;
    } entry_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[src/mwfb_ifs.sv]
// Channel interfaces for incoming register items and outgoing frame bytes.
interface mwfb_item_if;
    logic        valid;
    logic        ready;
    logic        first_of_frame;
    logic [7:0]  station_addr;
    logic [15:0] start_register;
    logic [6:0]  register_count;
    logic [15:0] register_value;

    modport source (output valid, first_of_frame, station_addr, start_register,
                    register_count, register_value, input ready);
    modport sink (input valid, first_of_frame, station_addr, start_register,
                  register_count, register_value, output ready);
endinterface

interface mwfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

[src/mwfb_front.sv]
// Front end: accepts items, tracks the open frame and classifies each item.
module mwfb_front
    import mwfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mwfb_item_if.sink item,
    input  logic   full,
    output logic   push,
    output entry_t entry
);

    logic [6:0] values_left_reg;
    logic [6:0] values_left_next;
    logic       in_frame_reg;
    logic       in_frame_next;
    logic       accept;
    logic [6:0] cnt;
    logic [6:0] left;

    assign item.ready = !full;
    assign accept = item.valid && item.ready;

    always_comb
    begin
        if (item.register_count == 7'd0)
        begin
            cnt = 7'd1;
        end
        else if (item.register_count > 7'(MAX_REGISTERS))
        begin
            cnt = 7'(MAX_REGISTERS);
        end
        else
        begin
            cnt = item.register_count;
        end
        left = item.first_of_frame ? cnt : values_left_reg;

        entry.first          = item.first_of_frame;
        entry.multi          = (cnt != 7'd1);
        entry.last           = (left <= 7'd1);
        entry.station_addr   = item.station_addr;
        entry.start_register = item.start_register;
        entry.register_count = cnt;
        entry.register_value = item.register_value;

        push = accept && (item.first_of_frame || in_frame_reg);

        values_left_next = values_left_reg;
        in_frame_next    = in_frame_reg;
        if (push)
        begin
            values_left_next = (left == 7'd0) ? 7'd0 : left - 7'd1;
            in_frame_next    = (left > 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            values_left_reg <= '0;
            in_frame_reg    <= 1'b0;
        end
        else
        begin
            values_left_reg <= values_left_next;
            in_frame_reg    <= in_frame_next;
        end
    end

endmodule

[src/mwfb_queue.sv]
// Short queue of classified items between the front end and the serializer.
module mwfb_queue
    import mwfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output entry_t head
);

    entry_t                slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     fill_reg;
    logic [QUEUE_AW:0]     fill_next;
    logic                  do_pop;

    assign full   = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty  = (fill_reg == '0);
    assign head   = slots_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

[src/mwfb_back.sv]
// Serializer: emits the frame bytes of each queued item and runs the CRC.
module mwfb_back
    import mwfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   empty,
    input  entry_t head,
    output logic   pop,
    mwfb_byte_if.source stream
);

    localparam logic [3:0] S_ADDR     = 4'd0;
    localparam logic [3:0] S_FUNC     = 4'd1;
    localparam logic [3:0] S_START_HI = 4'd2;
    localparam logic [3:0] S_START_LO = 4'd3;
    localparam logic [3:0] S_QTY_HI   = 4'd4;
    localparam logic [3:0] S_QTY_LO   = 4'd5;
    localparam logic [3:0] S_BCOUNT   = 4'd6;
    localparam logic [3:0] S_VAL_HI   = 4'd7;
    localparam logic [3:0] S_VAL_LO   = 4'd8;
    localparam logic [3:0] S_CRC_LO   = 4'd9;
    localparam logic [3:0] S_CRC_HI   = 4'd10;

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        started_reg;
    logic        started_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic [3:0]  cur_step;
    logic        fire;
    logic [7:0]  cur_byte;
    logic        cur_end;
    logic [15:0] crc_base;

    assign stream.valid      = out_valid_reg;
    assign stream.frame_byte = out_byte_reg;
    assign stream.frame_end  = out_end_reg;

    assign fire     = !empty && (!out_valid_reg || stream.ready);
    assign cur_step = started_reg ? step_reg : (head.first ? S_ADDR : S_VAL_HI);
    assign crc_base = (cur_step == S_ADDR) ? CRC_INIT : crc_reg;

    always_comb
    begin
        cur_end      = 1'b0;
        pop          = 1'b0;
        step_next    = step_reg;
        started_next = started_reg;
        unique case (cur_step)
            S_ADDR:     cur_byte = head.station_addr;
            S_FUNC:     cur_byte = head.multi ? FN_WRITE_MULTI : FN_WRITE_SINGLE;
            S_START_HI: cur_byte = head.start_register[15:8];
            S_START_LO: cur_byte = head.start_register[7:0];
            S_QTY_HI:   cur_byte = 8'h00;
            S_QTY_LO:   cur_byte = {1'b0, head.register_count};
            S_BCOUNT:   cur_byte = {head.register_count, 1'b0};
            S_VAL_HI:   cur_byte = head.register_value[15:8];
            S_VAL_LO:   cur_byte = head.register_value[7:0];
            S_CRC_LO:   cur_byte = crc_reg[7:0];
            S_CRC_HI:
            begin
                cur_byte = crc_reg[15:8];
                cur_end  = 1'b1;
            end
            default:    cur_byte = 8'h00;
        endcase

        crc_next = crc_reg;
        if (fire)
        begin
            if (cur_step == S_CRC_HI)
            begin
                crc_next = CRC_INIT;
            end
            else if (cur_step != S_CRC_LO)
            begin
                crc_next = crc_byte(crc_base, cur_byte);
            end

            started_next = 1'b1;
            unique case (cur_step)
                S_START_LO: step_next = head.multi ? S_QTY_HI : S_VAL_HI;
                S_VAL_LO:
                begin
                    if (head.last)
                    begin
                        step_next = S_CRC_LO;
                    end
                    else
                    begin
                        pop          = 1'b1;
                        started_next = 1'b0;
                    end
                end
                S_CRC_HI:
                begin
                    pop          = 1'b1;
                    started_next = 1'b0;
                end
                default:    step_next = cur_step + 4'd1;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg  <= cur_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_ADDR;
            started_reg   <= 1'b0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            started_reg <= started_next;
            crc_reg     <= crc_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[src/modbus_write_frame_builder.sv]
// Top level of the Modbus RTU write-request frame builder.
//
//   channel  direction  carries
//   item     in         one register value, plus header fields on a frame's first item
//   stream   out        one frame byte, frame_end on the CRC high byte
//
// The serializer emits one byte per cycle while an item is queued and stream is ready;
// a middle item has two bytes, the first item of a multi-register frame up to nine.
// A four-entry queue lets the input side run ahead of the output register.
// Reset clears the open-frame tracking, the queue and the output valid flag.
// A stalled stream holds its byte; the input stalls only when the queue is full.
module modbus_write_frame_builder
    import mwfb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    mwfb_item_if.sink item,
    mwfb_byte_if.source stream
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    entry_t push_entry;
    entry_t head;

    mwfb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .full  (full),
        .push  (push),
        .entry (push_entry)
    );

    mwfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    mwfb_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .stream (stream)
    );

endmodule

[dv/modbus_write_frame_builder_tb.sv]
// Self-checking testbench for the Modbus RTU write-request frame builder.
module modbus_write_frame_builder_tb
    import mwfb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 300;
    localparam int N_DIRECTED = 17;

    typedef struct packed {
        logic        first_of_frame;
        logic [7:0]  station_addr;
        logic [15:0] start_register;
        logic [6:0]  register_count;
        logic [15:0] register_value;
    } reg_item_t;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       last;
    } frame_byte_t;

    typedef struct packed {
        logic        first_of_frame;
        logic [7:0]  station_addr;
        logic [15:0] start_register;
        logic [6:0]  register_count;
        logic [15:0] register_value;
        int          n_bytes;
        int          lead_n;
        logic [55:0] lead_bytes;
    } directed_row_t;

    logic clk;
    logic rst_n;

    mwfb_item_if item_ch();
    mwfb_byte_if byte_ch();

    modbus_write_frame_builder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .stream (byte_ch)
    );

    frame_byte_t frame_bytes_q[$];

    logic [15:0] model_crc;
    logic [6:0]  model_left;
    logic        model_open;

    int  err_cnt = 0;
    int  items_sent = 0;
    int  ignored_cnt = 0;
    int  rand_items = 0;
    int  bytes_checked = 0;
    int  frames_closed = 0;
    int  holds_done = 0;
    bit  hold_req = 1'b0;
    bit  hold_started = 1'b0;
    bit  drained_once = 1'b0;
    bit  calm = 1'b0;

    directed_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{1'b0, 8'hFF, 16'hFFFF, 7'd127, 16'hFFFF, 0, 0, 56'h0},
        '{1'b1, 8'h00, 16'h0000, 7'd1,   16'h0000, 8, 6, 56'h00060000000000},
        '{1'b1, 8'hFF, 16'hFFFF, 7'd0,   16'hFFFF, 8, 6, 56'hFF06FFFFFFFF00},
        '{1'b1, 8'h01, 16'h1234, 7'd127, 16'hABCD, 9, 7, 56'h01101234007BF6},
        '{1'b1, 8'hA5, 16'h8000, 7'd2,   16'h00FF, 9, 7, 56'hA5108000000204},
        '{1'b0, 8'h5A, 16'h0F0F, 7'd85,  16'hFF00, 4, 2, 56'hFF000000000000},
        '{1'b0, 8'h12, 16'h3456, 7'd3,   16'h7777, 0, 0, 56'h0},
        '{1'b1, 8'h7F, 16'h0001, 7'd123, 16'h8001, 9, 7, 56'h7F100001007BF6},
        '{1'b0, 8'h00, 16'h0000, 7'd0,   16'h1234, 2, 2, 56'h12340000000000},
        '{1'b1, 8'h11, 16'h00FF, 7'd1,   16'hAAAA, 8, 6, 56'h110600FFAAAA00},
        '{1'b0, 8'hC3, 16'hFFFF, 7'd1,   16'h5555, 0, 0, 56'h0},
        '{1'b1, 8'h80, 16'h4000, 7'd64,  16'h5555, 9, 7, 56'h80104000004080},
        '{1'b1, 8'h08, 16'h0200, 7'd124, 16'h0102, 9, 7, 56'h08100200007BF6},
        '{1'b1, 8'h02, 16'h0010, 7'd3,   16'h0304, 9, 7, 56'h02100010000306},
        '{1'b0, 8'hEE, 16'hBEEF, 7'd99,  16'h0506, -1, 0, 56'h0},
        '{1'b0, 8'h3C, 16'h7FFF, 7'd42,  16'h0708, 4, 2, 56'h07080000000000},
        '{1'b0, 8'h01, 16'h0001, 7'd1,   16'h0001, 0, 0, 56'h0}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("modbus_write_frame_builder test failed");
        $finish;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
            begin
                c = {1'b0, c[15:1]} ^ CRC_POLY;
            end
            else
            begin
                c = {1'b0, c[15:1]};
            end
        end
        return c;
    endfunction

    function automatic void push_frame_byte(input logic [7:0] b, input logic last,
                                            input logic fold);
        frame_byte_t e;
        e.fbyte = b;
        e.last = last;
        frame_bytes_q.push_back(e);
        if (fold)
        begin
            model_crc = crc16_update(model_crc, b);
        end
    endfunction

    function automatic int predict_frame_bytes(input reg_item_t it);
        logic [6:0] cnt;
        int n0;
        n0 = frame_bytes_q.size();
        cnt = it.register_count;
        if (it.first_of_frame)
        begin
            if (cnt == 7'd0)
            begin
                cnt = 7'd1;
            end
            if (cnt > MAX_REGISTERS)
            begin
                cnt = 7'(MAX_REGISTERS);
            end
            model_crc = CRC_INIT;
            model_open = 1'b1;
            model_left = cnt;
            push_frame_byte(it.station_addr, 1'b0, 1'b1);
            push_frame_byte((cnt == 7'd1) ? FN_WRITE_SINGLE : FN_WRITE_MULTI, 1'b0, 1'b1);
            push_frame_byte(it.start_register[15:8], 1'b0, 1'b1);
            push_frame_byte(it.start_register[7:0], 1'b0, 1'b1);
            if (cnt != 7'd1)
            begin
                push_frame_byte(8'h00, 1'b0, 1'b1);
                push_frame_byte({1'b0, cnt}, 1'b0, 1'b1);
                push_frame_byte({cnt, 1'b0}, 1'b0, 1'b1);
            end
        end
        else if (!model_open)
        begin
            ignored_cnt++;
            return 0;
        end
        push_frame_byte(it.register_value[15:8], 1'b0, 1'b1);
        push_frame_byte(it.register_value[7:0], 1'b0, 1'b1);
        if (model_left != 7'd0)
        begin
            model_left = model_left - 7'd1;
        end
        if (model_left == 7'd0)
        begin
            push_frame_byte(model_crc[7:0], 1'b0, 1'b0);
            push_frame_byte(model_crc[15:8], 1'b1, 1'b0);
            model_crc = CRC_INIT;
            model_open = 1'b0;
        end
        return frame_bytes_q.size() - n0;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic reg_item_t random_item();
        reg_item_t it;
        it.first_of_frame = 1'b0;
        it.station_addr = 8'($urandom);
        it.start_register = 16'($urandom);
        it.register_count = 7'($urandom);
        it.register_value = 16'($urandom);
        return it;
    endfunction

    task automatic idle_input(input int n);
        repeat (n)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_item(input reg_item_t it, output int nres);
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.first_of_frame <= it.first_of_frame;
        item_ch.station_addr <= it.station_addr;
        item_ch.start_register <= it.start_register;
        item_ch.register_count <= it.register_count;
        item_ch.register_value <= it.register_value;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        nres = predict_frame_bytes(it);
        items_sent++;
    endtask

    task automatic send_random_frame();
        reg_item_t it;
        int kind;
        int r;
        int cnt;
        int eff;
        int nvals;
        int nres;
        int g;
        kind = $urandom_range(0, 99);
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            cnt = 0;
        end
        else if (r < 50)
        begin
            cnt = $urandom_range(1, 4);
        end
        else if (r < 85)
        begin
            cnt = $urandom_range(5, 16);
        end
        else if (r < 96 || rand_items > 200)
        begin
            cnt = $urandom_range(17, 40);
        end
        else
        begin
            cnt = $urandom_range(41, 127);
        end
        eff = (cnt == 0) ? 1 : ((cnt > MAX_REGISTERS) ? MAX_REGISTERS : cnt);
        nvals = eff;
        if (kind < 8)
        begin
            nvals = 0;
        end
        else if (kind < 18)
        begin
            nvals = $urandom_range(1, eff);
        end
        if (rand_items >= 160 && !drained_once)
        begin
            idle_input(1);
            while (frame_bytes_q.size() != 0)
            begin
                @(posedge clk);
            end
            drained_once = 1'b1;
        end
        if (nvals == 0)
        begin
            it = random_item();
            send_item(it, nres);
            g = gap_len();
            if (g > 0)
            begin
                idle_input(g);
            end
        end
        for (int i = 0; i < nvals; i++)
        begin
            it = random_item();
            if (i == 0)
            begin
                it.first_of_frame = 1'b1;
                it.register_count = 7'(cnt);
            end
            if (rand_items >= 80 && !hold_started)
            begin
                hold_started = 1'b1;
                hold_req = 1'b1;
            end
            send_item(it, nres);
            if (nres > 0)
            begin
                rand_items++;
                if (rand_items % 50 == 0)
                begin
                    calm = ($urandom_range(0, 3) == 0);
                end
            end
            g = gap_len();
            if (g > 0)
            begin
                idle_input(g);
            end
        end
    endtask

    initial
    begin
        reg_item_t it;
        directed_row_t row;
        int nres;
        int base;
        int g;
        rst_n = 1'b0;
        model_crc = CRC_INIT;
        model_left = 7'd0;
        model_open = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.first_of_frame = 1'b0;
        item_ch.station_addr = 8'h00;
        item_ch.start_register = 16'h0000;
        item_ch.register_count = 7'd0;
        item_ch.register_value = 16'h0000;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
        begin
            row = directed_rows[k];
            it.first_of_frame = row.first_of_frame;
            it.station_addr = row.station_addr;
            it.start_register = row.start_register;
            it.register_count = row.register_count;
            it.register_value = row.register_value;
            send_item(it, nres);
            if (row.n_bytes >= 0 && nres != row.n_bytes)
            begin
                $display("%0t: directed item %0d gives %0d bytes, expected %0d",
                         $time, k, nres, row.n_bytes);
                err_cnt++;
            end
            base = frame_bytes_q.size() - nres;
            for (int j = 0; j < row.lead_n && j < nres; j++)
            begin
                if (frame_bytes_q[base + j].fbyte != row.lead_bytes[55 - 8 * j -: 8])
                begin
                    $display("%0t: directed item %0d byte %0d, expected %02h, predicted %02h",
                             $time, k, j, row.lead_bytes[55 - 8 * j -: 8],
                             frame_bytes_q[base + j].fbyte);
                    err_cnt++;
                end
            end
            g = gap_len();
            if (g > 0)
            begin
                idle_input(g);
            end
        end

        while (rand_items < RANDOM_ITEMS)
        begin
            send_random_frame();
        end

        idle_input(1);
        while (frame_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d items (%0d outside a frame), checked %0d bytes in %0d frames.",
                 items_sent, ignored_cnt, bytes_checked, frames_closed);
        $display("Output held off for %0d long stretch(es); input drained %0d time(s).",
                 holds_done, drained_once);
        if (err_cnt == 0)
        begin
            $display("modbus_write_frame_builder test passed");
        end
        else
        begin
            $display("modbus_write_frame_builder test failed");
        end
        $finish;
    end

    initial
    begin
        int n;
        byte_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                byte_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else if (calm)
            begin
                byte_ch.ready <= 1'b1;
            end
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 4)
                begin
                    byte_ch.ready <= 1'b0;
                    repeat ($urandom_range(8, 30)) @(negedge clk);
                end
                else
                begin
                    byte_ch.ready <= (n < 75);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (frame_bytes_q.size() == 0)
            begin
                $display("%0t: byte %02h with frame_end %0b arrived with nothing expected",
                         $time, byte_ch.frame_byte, byte_ch.frame_end);
                err_cnt++;
            end
            else
            begin
                want = frame_bytes_q.pop_front();
                bytes_checked++;
                if (byte_ch.frame_byte !== want.fbyte)
                begin
                    $display("%0t: frame_byte mismatch, expected %02h, got %02h",
                             $time, want.fbyte, byte_ch.frame_byte);
                    err_cnt++;
                end
                if (byte_ch.frame_end !== want.last)
                begin
                    $display("%0t: frame_end mismatch, expected %0b, got %0b",
                             $time, want.last, byte_ch.frame_end);
                    err_cnt++;
                end
                if (want.last)
                begin
                    frames_closed++;
                end
            end
        end
    end

endmodule
